// ===== hw/rtl/rdc_pkg.sv =====
// shared widths, register indexes and the chain control type for the radix digit converter
package rdc_pkg;

   localparam int VALUE_W = 64;
   localparam int DIGIT_W = 4;
   localparam int RADIX_W = 5;
   localparam int CHAR_W = 8;
   localparam int ALPHA_W = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 64;

   localparam int DEF_MAX_DIGITS = 64;
   localparam int DEF_MAX_RADIX = 16;

   localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
   localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);

   localparam logic [CSR_INDEX_W-1:0] CSR_RADIX = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_LOW = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_HIGH = 2'd2;

   typedef struct packed {
      logic clear;
      logic convert;
      logic shift;
   } chain_ctrl_type;

endpackage

// ===== hw/rtl/rdc_cell.sv =====
// one digit cell: doubles its digit plus the incoming carry modulo the radix, shifts up, or clears
module rdc_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  rdc_pkg::chain_ctrl_type        ctrl,
   input  logic [rdc_pkg::RADIX_W-1:0]    radix,
   input  logic                           carry_in,
   input  logic                           valid_in,
   input  logic [rdc_pkg::DIGIT_W-1:0]    digit_in,
   output logic [rdc_pkg::DIGIT_W-1:0]    digit_out,
   output logic                           carry_out,
   output logic                           valid_out
);
   import rdc_pkg::*;

   logic [DIGIT_W-1:0] digit_ff;
   logic               carry_ff;
   logic               valid_ff;
   logic [RADIX_W-1:0] sum;
   logic [RADIX_W-1:0] diff;
   logic               wrap;

   assign sum = {digit_ff, carry_in};
   assign diff = sum - radix;
   assign wrap = (sum >= radix);

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff <= '0;
         valid_ff <= 1'b0;
      end else if (ctrl.clear) begin
         digit_ff <= '0;
         valid_ff <= 1'b0;
      end else if (ctrl.convert) begin
         valid_ff <= valid_in;
         if (valid_in) begin
            digit_ff <= wrap ? diff[DIGIT_W-1:0] : sum[DIGIT_W-1:0];
         end
      end else if (ctrl.shift) begin
         digit_ff <= digit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.convert && valid_in) begin
         carry_ff <= wrap;
      end
   end

   assign digit_out = digit_ff;
   assign carry_out = carry_ff;
   assign valid_out = valid_ff;

endmodule

// ===== hw/rtl/rdc_digit_chain.sv =====
// row of digit cells, least significant digit in cell 0, carries ripple up one cell a cycle
module rdc_digit_chain #(
   parameter int MAX_DIGITS = rdc_pkg::DEF_MAX_DIGITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rdc_pkg::chain_ctrl_type        ctrl,
   input  logic [rdc_pkg::RADIX_W-1:0]    radix,
   input  logic                           bit_in,
   input  logic                           bit_valid,
   output logic [rdc_pkg::DIGIT_W-1:0]    digit_top,
   output logic                           carry_top,
   output logic                           valid_top
);
   import rdc_pkg::*;

   logic [DIGIT_W-1:0] digit [MAX_DIGITS];
   logic               carry [MAX_DIGITS];
   logic               valid [MAX_DIGITS];

   for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
      if (k == 0) begin : g_first
         rdc_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .radix     (radix),
            .carry_in  (bit_in),
            .valid_in  (bit_valid),
            .digit_in  ('0),
            .digit_out (digit[k]),
            .carry_out (carry[k]),
            .valid_out (valid[k])
         );
      end else begin : g_next
         rdc_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .radix     (radix),
            .carry_in  (carry[k-1]),
            .valid_in  (valid[k-1]),
            .digit_in  (digit[k-1]),
            .digit_out (digit[k]),
            .carry_out (carry[k]),
            .valid_out (valid[k])
         );
      end
   end

   assign digit_top = digit[MAX_DIGITS-1];
   assign carry_top = carry[MAX_DIGITS-1];
   assign valid_top = valid[MAX_DIGITS-1];

endmodule

// ===== hw/rtl/radix_digit_converter.sv =====
// top level: unsigned 64-bit value to alphabet characters in a configurable radix
//
// usage
//   req_* carries one item per value (tdata = value). rsp_* returns one item
//   per digit, most significant first, with tdata = character and tlast set on
//   the least significant digit. leading zeros are dropped; zero gives one item.
//   csr_we/csr_index/csr_wdata write radix (0), alphabet_low (1) and
//   alphabet_high (2); write only while the block is idle.
// timing
//   the value enters the cell row one bit a cycle, msb first, and the carries
//   ripple up one cell a cycle until the row holds the digits of the value.
//   the digits then leave the top of the row one a cycle, one per digit
//   whether dropped or sent; a digit to be sent waits for the output register.
// reset and stalls
//   reset empties the row and the output register and restores the default
//   radix of 10 and an all-zero alphabet. a stalled receiver holds the output
//   register and the row waits; the next value is taken while the last
//   character still waits in the output register.
module radix_digit_converter #(
   parameter int MAX_DIGITS = rdc_pkg::DEF_MAX_DIGITS,
   parameter int MAX_RADIX  = rdc_pkg::DEF_MAX_RADIX
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rdc_pkg::VALUE_W-1:0]       req_tdata,   // value
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rdc_pkg::CHAR_W-1:0]        rsp_tdata,   // character
   output logic                              rsp_tlast,   // last_digit
   input  logic                              csr_we,
   input  logic [rdc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rdc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rdc_pkg::*;

   localparam int CYC_W = $clog2(VALUE_W + MAX_DIGITS + 1);
   localparam int POS_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam logic [CYC_W-1:0] CYC_FEED = CYC_W'(VALUE_W);
   localparam logic [CYC_W-1:0] CYC_END = CYC_W'(VALUE_W + MAX_DIGITS - 1);
   localparam logic [POS_W-1:0] POS_TOP = POS_W'(MAX_DIGITS - 1);
   localparam logic [RADIX_W-1:0] RADIX_CAP = RADIX_W'(MAX_RADIX);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [RADIX_W-1:0]     radix_ff;
   logic [ALPHA_W-1:0]     alpha_low_ff;
   logic [ALPHA_W-1:0]     alpha_high_ff;
   logic [VALUE_W-1:0]     value_ff, value_in;
   logic [CYC_W-1:0]       cyc_ff, cyc_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic                   started_ff, started_in;
   logic                   ovf_ff, ovf_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]      rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [RADIX_W-1:0]     radix_eff;
   chain_ctrl_type         ctrl;
   logic                   accept;
   logic                   out_free;
   logic                   emit_now;
   logic                   bit_valid;
   logic [DIGIT_W-1:0]     digit_top;
   logic                   carry_top;
   logic                   valid_top;
   logic [2*ALPHA_W-1:0]   alphabet;

   always_comb begin
      if (radix_ff < RADIX_MIN) begin
         radix_eff = RADIX_MIN;
      end else if (radix_ff > RADIX_CAP) begin
         radix_eff = RADIX_CAP;
      end else begin
         radix_eff = radix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
         alpha_low_ff <= '0;
         alpha_high_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RADIX: begin
               radix_ff <= csr_wdata[RADIX_W-1:0];
            end
            CSR_ALPHA_LOW: begin
               alpha_low_ff <= csr_wdata[ALPHA_W-1:0];
            end
            CSR_ALPHA_HIGH: begin
               alpha_high_ff <= csr_wdata[ALPHA_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign alphabet = {alpha_high_ff, alpha_low_ff};
   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign bit_valid = (state_ff == ST_LOAD) && (cyc_ff < CYC_FEED);
   assign emit_now = started_ff || (digit_top != '0) || (pos_ff == '0) || ovf_ff;

   assign ctrl.clear = accept;
   assign ctrl.convert = (state_ff == ST_LOAD);
   assign ctrl.shift = (state_ff == ST_EMIT) && (!emit_now || out_free);

   rdc_digit_chain #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .radix     (radix_eff),
      .bit_in    (value_ff[VALUE_W-1]),
      .bit_valid (bit_valid),
      .digit_top (digit_top),
      .carry_top (carry_top),
      .valid_top (valid_top)
   );

   always_comb begin
      state_in = state_ff;
      value_in = value_ff;
      cyc_in = cyc_ff;
      pos_in = pos_ff;
      started_in = started_ff;
      ovf_in = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               value_in = req_tdata;
               cyc_in = '0;
               ovf_in = 1'b0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            value_in = {value_ff[VALUE_W-2:0], 1'b0};
            cyc_in = cyc_ff + 1'b1;
            if (valid_top && carry_top) begin
               ovf_in = 1'b1;
            end
            if (cyc_ff == CYC_END) begin
               pos_in = POS_TOP;
               started_in = 1'b0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!emit_now) begin
               pos_in = pos_ff - 1'b1;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in = alphabet[{digit_top, 3'b000} +: CHAR_W];
               rsp_last_in = (pos_ff == '0);
               started_in = 1'b1;
               if (pos_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  pos_in = pos_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cyc_ff <= '0;
         pos_ff <= '0;
         started_ff <= 1'b0;
         ovf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cyc_ff <= cyc_in;
         pos_ff <= pos_in;
         started_ff <= started_in;
         ovf_ff <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_char_ff;
   assign rsp_tlast = rsp_last_ff;

endmodule

// ===== dv/tb.sv =====
// testbench for radix_digit_converter: directed and random values against a digit predictor
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rdc_pkg::*;

   localparam int CELL_IDX_W = $clog2(DEF_MAX_DIGITS);

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last_digit;
   } char_item_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [VALUE_W-1:0]     req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [CHAR_W-1:0]      rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   radix_digit_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // shadow copy of the registers
   logic [RADIX_W-1:0] radix_reg = RADIX_RESET;
   logic [ALPHA_W-1:0] alpha_low_reg = '0;
   logic [ALPHA_W-1:0] alpha_high_reg = '0;

   char_item_type expected_chars[$];
   int         errors = 0;
   int         values_sent = 0;
   int         chars_checked = 0;
   int         settings_used = 0;
   int         longest_number = 0;
   logic [16:0] bases_seen = '0;
   bit         gap_enable = 1'b0;
   bit         stall_enable = 1'b0;
   int         hold_off = 0;

   always #1 clock = ~clock;

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic int random_pause(input bit enable);
      int pick;
      pick = $urandom_range(0, 99);
      if (!enable || pick < 60)
         return 0;
      else if (pick < 90)
         return $urandom_range(1, 3);
      else if (pick < 98)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 60);
   endfunction

   function automatic logic [CHAR_W-1:0] char_of_digit(input logic [DIGIT_W-1:0] digit);
      if (digit < 8)
         return alpha_low_reg[{digit[2:0], 3'b000} +: 8];
      else
         return alpha_high_reg[{digit[2:0], 3'b000} +: 8];
   endfunction

   // splits a value into digits and queues the characters, most significant first
   function automatic void predict_digits(input logic [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] base;
      logic [VALUE_W-1:0] rest;
      logic [DIGIT_W-1:0] cells[DEF_MAX_DIGITS];
      int                 count;
      char_item_type      item;
      base = VALUE_W'(radix_reg);
      if (base < 2)
         base = 2;
      if (base > DEF_MAX_RADIX)
         base = DEF_MAX_RADIX;
      bases_seen[base[4:0]] = 1'b1;
      rest = value;
      count = 0;
      do begin
         cells[CELL_IDX_W'(count)] = DIGIT_W'(rest % base);
         rest = rest / base;
         count++;
      end while (rest != 0 && count < DEF_MAX_DIGITS);
      for (int i = count - 1; i >= 0; i--) begin
         item.character = char_of_digit(cells[CELL_IDX_W'(i)]);
         item.last_digit = (i == 0);
         expected_chars.push_back(item);
      end
      if (count > longest_number)
         longest_number = count;
   endfunction

   function automatic logic [VALUE_W-1:0] rand_value();
      logic [VALUE_W-1:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: return VALUE_W'($urandom_range(0, 40));
         1: return '1;
         2, 3: return v;
         default: return v >> $urandom_range(1, 63);
      endcase
   endfunction

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_RADIX:      radix_reg = data[RADIX_W-1:0];
         CSR_ALPHA_LOW:  alpha_low_reg = data;
         CSR_ALPHA_HIGH: alpha_high_reg = data;
         default: ;
      endcase
      settings_used++;
      @(posedge clock);
   endtask

   // radix write with junk in the unused upper bits
   task automatic set_radix(input logic [RADIX_W-1:0] base);
      logic [CSR_DATA_W-1:0] data;
      data = {$urandom, $urandom};
      data[RADIX_W-1:0] = base;
      csr_write(CSR_RADIX, data);
   endtask

   task automatic send_value(input logic [VALUE_W-1:0] value);
      int gap;
      gap = random_pause(gap_enable);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      do @(posedge clock); while (!req_tready);
      predict_digits(value);
      values_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   initial begin : result_checker
      char_item_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected item: character %h last_digit %b", rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               want = expected_chars.pop_front();
               chars_checked++;
               if (rsp_tdata !== want.character) begin
                  $error("character: expected %h, got %h", want.character, rsp_tdata);
                  errors++;
               end
               if (rsp_tlast !== want.last_digit) begin
                  $error("last_digit: expected %b, got %b", want.last_digit, rsp_tlast);
                  errors++;
               end
            end
         end
      end
   end

   initial begin : receiver
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            hold_off--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = random_pause(stall_enable);
         end
      end
   end

   task automatic test_reset_defaults();
      // radix 10 and an all-zero alphabet
      send_value('0);
      send_value(64'd12345);
      send_value('1);
      wait_idle();
   endtask

   task automatic test_directed_values();
      csr_write(CSR_ALPHA_LOW, 64'h3736353433323130);
      csr_write(CSR_ALPHA_HIGH, 64'h6665646362613938);
      set_radix(5'd16);
      send_value('0);
      send_value(64'h1);
      send_value(64'hF);
      send_value(64'h10);
      send_value('1);
      send_value(64'h8000_0000_0000_0000);
      wait_idle();
      set_radix(5'd2);
      send_value('1);
      send_value(64'h1);
      send_value(64'h8000_0000_0000_0000);
      wait_idle();
      set_radix(5'd10);
      send_value(64'd9);
      send_value(64'd10);
      send_value(64'd10_000_000_000_000_000_000);
      send_value('1);
      wait_idle();
   endtask

   task automatic test_radix_clamp();
      csr_write(CSR_ALPHA_LOW, {$urandom, $urandom});
      csr_write(CSR_ALPHA_HIGH, {$urandom, $urandom});
      // bases below two behave as two, above the cap as sixteen
      set_radix(5'd0);
      send_value(64'd5);
      wait_idle();
      set_radix(5'd1);
      send_value('1);
      wait_idle();
      set_radix(5'd17);
      send_value('1);
      wait_idle();
      set_radix(5'd31);
      send_value(64'h123);
      send_value(64'h0);
      wait_idle();
   endtask

   task automatic test_backpressure();
      set_radix(5'd2);
      gap_enable = 1'b0;
      stall_enable = 1'b0;
      hold_off = 700;
      for (int i = 0; i < 8; i++)
         send_value({$urandom, $urandom});
      // sender pauses until the queue has drained
      wait_idle();
      gap_enable = 1'b1;
      stall_enable = 1'b1;
      for (int i = 0; i < 4; i++)
         send_value(rand_value());
      wait_idle();
   endtask

   task automatic test_random_settings();
      logic [RADIX_W-1:0] base;
      for (int phase = 0; phase < 14; phase++) begin
         if (phase == 0)
            base = 5'd2;
         else if (phase == 1)
            base = 5'd16;
         else if ($urandom_range(0, 9) < 7)
            base = RADIX_W'($urandom_range(2, 16));
         else
            base = RADIX_W'($urandom_range(0, 31));
         set_radix(base);
         if ($urandom_range(0, 3) != 0)
            csr_write(CSR_ALPHA_LOW, {$urandom, $urandom});
         if ($urandom_range(0, 3) != 0)
            csr_write(CSR_ALPHA_HIGH, {$urandom, $urandom});
         gap_enable = (phase % 4 != 3);
         stall_enable = (phase % 5 != 4);
         for (int i = 0; i < 24; i++)
            send_value(rand_value());
         wait_idle();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_values();
      test_radix_clamp();
      test_backpressure();
      test_random_settings();
      wait_idle();
      repeat (300) @(posedge clock);
      $display("converted %0d values into %0d characters, %0d register writes",
               values_sent, chars_checked, settings_used);
      $display("bases seen (bit per base) %b, longest number %0d digits",
               bases_seen, longest_number);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/rdc_pkg.sv
hw/rtl/rdc_cell.sv
hw/rtl/rdc_digit_chain.sv
hw/rtl/radix_digit_converter.sv
dv/tb.sv
